// ===== rtl/lgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared constants and types for the Life generation row stencil block.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    // Fixed widths of the row and result fields.
    localparam int CELLS      = 64;
    localparam int WIDTH_W    = 7;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_CNT_W  = 7;
    localparam int TOTAL_W    = 19;

    // Grid limits.
    localparam int ROW_WIDTH  = 64;
    localparam int MAX_ROWS   = 4096;

    // Rule counts (B3/S23).
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // Lane partitioning of one row.
    localparam int LANE_CELLS = 8;
    localparam int LANES      = CELLS / LANE_CELLS;
    localparam int LANE_CNT_W = $clog2(LANE_CELLS + 1);
    localparam int NBR_CNT_W  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int GRID_WIDTH_RESET  = 64;
    localparam int GRID_HEIGHT_RESET = 64;

    // Height limit as seen through the 13-bit register.
    localparam int MAX_ROWS_LIM = (MAX_ROWS < (1 << HEIGHT_W) - 1) ? MAX_ROWS
                                                                  : (1 << HEIGHT_W) - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 4'd0,
        REG_GRID_HEIGHT = 4'd1
    } cfg_reg_t;

    // One generation job: the three rows around the target row.
    typedef struct packed {
        logic [CELLS-1:0] up;
        logic [CELLS-1:0] mid;
        logic [CELLS-1:0] down;
        logic [CELLS-1:0] mask;
        logic             last;
    } job_t;

    // What the lanes found for one job.
    typedef struct packed {
        logic [CELLS-1:0]                 next_row;
        logic [LANES-1:0][LANE_CNT_W-1:0] counts;
        logic                             last;
    } lane_res_t;

endpackage

// ===== rtl/lgrs_lane.sv =====
// ----------------------------------------------------------------------------
// lgrs_lane
// Next-generation state and change count for one slice of a row.
// ----------------------------------------------------------------------------
module lgrs_lane (
    input  logic [lgrs_pkg::LANE_CELLS+1:0]  up_win,
    input  logic [lgrs_pkg::LANE_CELLS+1:0]  mid_win,
    input  logic [lgrs_pkg::LANE_CELLS+1:0]  down_win,
    input  logic [lgrs_pkg::LANE_CELLS-1:0]  mask,
    output logic [lgrs_pkg::LANE_CELLS-1:0]  next_bits,
    output logic [lgrs_pkg::LANE_CNT_W-1:0]  change_cnt
);

    logic [lgrs_pkg::LANE_CELLS-1:0] changed;

    // Window bit c+1 is cell c; the outer bits are the neighbors of the slice.
    always_comb
    begin
        logic [lgrs_pkg::NBR_CNT_W-1:0] n;
        for (int c = 0; c < lgrs_pkg::LANE_CELLS; c++)
        begin
            n = lgrs_pkg::NBR_CNT_W'(up_win[c])   + lgrs_pkg::NBR_CNT_W'(up_win[c+1])
              + lgrs_pkg::NBR_CNT_W'(up_win[c+2]) + lgrs_pkg::NBR_CNT_W'(mid_win[c])
              + lgrs_pkg::NBR_CNT_W'(mid_win[c+2]) + lgrs_pkg::NBR_CNT_W'(down_win[c])
              + lgrs_pkg::NBR_CNT_W'(down_win[c+1]) + lgrs_pkg::NBR_CNT_W'(down_win[c+2]);
            next_bits[c] = mask[c]
                && ((n == lgrs_pkg::NBR_CNT_W'(lgrs_pkg::BIRTH_COUNT))
                    || ((n == lgrs_pkg::NBR_CNT_W'(lgrs_pkg::SURVIVE_COUNT)) && mid_win[c+1]));
        end
    end

    assign changed = (next_bits ^ mid_win[lgrs_pkg::LANE_CELLS:1]) & mask;

    always_comb
    begin
        change_cnt = '0;
        for (int c = 0; c < lgrs_pkg::LANE_CELLS; c++)
        begin
            change_cnt = change_cnt + lgrs_pkg::LANE_CNT_W'(changed[c]);
        end
    end

endmodule

// ===== rtl/lgrs_merge.sv =====
// ----------------------------------------------------------------------------
// lgrs_merge
// Registers the lane results, sums the lane counts, keeps the frame total
// and holds the output register.
// ----------------------------------------------------------------------------
module lgrs_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    output logic                              res_ready,
    input  lgrs_pkg::lane_res_t               res,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lgrs_pkg::CELLS-1:0]        next_row,
    output logic [lgrs_pkg::ROW_CNT_W-1:0]    row_changes,
    output logic [lgrs_pkg::TOTAL_W-1:0]      frame_changes,
    output logic                              frame_last
);

    logic                               s1_valid_reg;
    lgrs_pkg::lane_res_t                s1_reg;
    logic                               out_valid_reg;
    logic [lgrs_pkg::CELLS-1:0]         next_row_reg;
    logic [lgrs_pkg::ROW_CNT_W-1:0]     row_changes_reg;
    logic [lgrs_pkg::TOTAL_W-1:0]       frame_changes_reg;
    logic                               frame_last_reg;
    logic [lgrs_pkg::TOTAL_W-1:0]       total_reg;
    logic [lgrs_pkg::TOTAL_W-1:0]       total_next;
    logic [lgrs_pkg::ROW_CNT_W-1:0]     row_sum;
    logic                               out_take;

    assign out_take  = !out_valid_reg || !out_stall;
    assign res_ready = !s1_valid_reg || out_take;

    always_comb
    begin
        row_sum = '0;
        for (int l = 0; l < lgrs_pkg::LANES; l++)
        begin
            row_sum = row_sum + lgrs_pkg::ROW_CNT_W'(s1_reg.counts[l]);
        end
    end

    assign total_next = total_reg + lgrs_pkg::TOTAL_W'(row_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (res_ready)
            begin
                s1_valid_reg <= res_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
                // The total starts over once the final row of a frame goes out.
                if (s1_valid_reg)
                begin
                    total_reg <= s1_reg.last ? '0 : total_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            s1_reg <= res;
        end
        if (out_take && s1_valid_reg)
        begin
            next_row_reg      <= s1_reg.next_row;
            row_changes_reg   <= row_sum;
            frame_changes_reg <= total_next;
            frame_last_reg    <= s1_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_row      = next_row_reg;
    assign row_changes   = row_changes_reg;
    assign frame_changes = frame_changes_reg;
    assign frame_last    = frame_last_reg;

endmodule

// ===== rtl/life_generation_row_stencil_top.sv =====
// ----------------------------------------------------------------------------
// life_generation_row_stencil_top
// One Conway Life generation (B3/S23) over a grid streamed one row per
// transfer.
// ----------------------------------------------------------------------------
// The block takes one row per cycle while in_stall is low; each row after the
// first of a frame yields the next state of the row before it. A final row
// with a row before it yields two result rows, so it holds off the next row
// while its own job waits: both go through the single array of eight lanes,
// which evaluates one row per cycle unless the merge stage holds it. Results
// pass the job, merge stage and output registers, the second of a final row
// after waiting in the pending job register; the output register lets the
// next row enter while a result waits. Each result carries its row's count of
// changed cells and the running frame total, which is zero for a stable grid.
// ----------------------------------------------------------------------------
module life_generation_row_stencil_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lgrs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lgrs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lgrs_pkg::CELLS-1:0]            row_cells,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lgrs_pkg::CELLS-1:0]            next_row,
    output logic [lgrs_pkg::ROW_CNT_W-1:0]        row_changes,
    output logic [lgrs_pkg::TOTAL_W-1:0]          frame_changes,
    output logic                                  frame_last
);

    localparam logic [lgrs_pkg::HEIGHT_W:0] MAX_ROWS_CLIP =
        (lgrs_pkg::HEIGHT_W+1)'(lgrs_pkg::MAX_ROWS_LIM);

    logic [lgrs_pkg::WIDTH_W-1:0]   width_reg;
    logic [lgrs_pkg::HEIGHT_W-1:0]  height_reg;
    logic [lgrs_pkg::CELLS-1:0]     upper_reg;
    logic [lgrs_pkg::CELLS-1:0]     middle_reg;
    logic [lgrs_pkg::HEIGHT_W-1:0]  row_index_reg;
    lgrs_pkg::job_t                 job_reg;
    logic                           job_valid_reg;
    lgrs_pkg::job_t                 pend_reg;
    logic                           pend_valid_reg;

    logic [lgrs_pkg::CELLS-1:0]     mask;
    logic [lgrs_pkg::CELLS-1:0]     row;
    logic [lgrs_pkg::HEIGHT_W:0]    eff_height;
    logic                           last;
    logic                           has_prev;
    logic                           accept;
    logic                           job_take;
    logic                           res_ready;
    lgrs_pkg::job_t                 job_prev;
    lgrs_pkg::job_t                 job_final;
    lgrs_pkg::lane_res_t            lane_res;
    logic [lgrs_pkg::CELLS+1:0]     up_pad;
    logic [lgrs_pkg::CELLS+1:0]     mid_pad;
    logic [lgrs_pkg::CELLS+1:0]     down_pad;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lgrs_pkg::WIDTH_W'(lgrs_pkg::GRID_WIDTH_RESET);
            height_reg <= lgrs_pkg::HEIGHT_W'(lgrs_pkg::GRID_HEIGHT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lgrs_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data[lgrs_pkg::WIDTH_W-1:0];
                lgrs_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data[lgrs_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row intake and job building
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < lgrs_pkg::CELLS; c++)
        begin
            mask[c] = (c < lgrs_pkg::ROW_WIDTH)
                   && (width_reg > lgrs_pkg::WIDTH_W'(c));
        end
    end

    always_comb
    begin
        eff_height = {1'b0, height_reg};
        if (height_reg == '0)
        begin
            eff_height = (lgrs_pkg::HEIGHT_W+1)'(1);
        end
        else if (eff_height > MAX_ROWS_CLIP)
        begin
            eff_height = MAX_ROWS_CLIP;
        end
    end

    assign row      = row_cells & mask;
    assign has_prev = (row_index_reg != '0);
    assign last     = ({1'b0, row_index_reg} + (lgrs_pkg::HEIGHT_W+1)'(1)) >= eff_height;

    assign job_take = !job_valid_reg || res_ready;
    assign in_stall = pend_valid_reg || !job_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        job_prev.up    = upper_reg & mask;
        job_prev.mid   = middle_reg & mask;
        job_prev.down  = row;
        job_prev.mask  = mask;
        job_prev.last  = 1'b0;

        job_final.up   = has_prev ? (middle_reg & mask) : '0;
        job_final.mid  = row;
        job_final.down = '0;
        job_final.mask = mask;
        job_final.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg      <= '0;
            middle_reg     <= '0;
            row_index_reg  <= '0;
            job_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last)
                begin
                    upper_reg     <= '0;
                    middle_reg    <= '0;
                    row_index_reg <= '0;
                end
                else
                begin
                    upper_reg     <= has_prev ? middle_reg : '0;
                    middle_reg    <= row;
                    row_index_reg <= row_index_reg + lgrs_pkg::HEIGHT_W'(1);
                end
            end
            if (job_take)
            begin
                if (pend_valid_reg)
                begin
                    job_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                else
                begin
                    job_valid_reg  <= accept && (has_prev || last);
                    pend_valid_reg <= accept && has_prev && last;
                end
            end
        end
    end

    // A final row with a row before it issues that row's job first and keeps
    // its own job waiting in the pending register.
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            if (pend_valid_reg)
            begin
                job_reg <= pend_reg;
            end
            else if (accept)
            begin
                job_reg <= has_prev ? job_prev : job_final;
            end
        end
        if (job_take && !pend_valid_reg && accept)
        begin
            pend_reg <= job_final;
        end
    end

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    assign up_pad   = {1'b0, job_reg.up,   1'b0};
    assign mid_pad  = {1'b0, job_reg.mid,  1'b0};
    assign down_pad = {1'b0, job_reg.down, 1'b0};
    assign lane_res.last = job_reg.last;

    for (genvar l = 0; l < lgrs_pkg::LANES; l++)
    begin : g_lane
        lgrs_lane u_lane (
            .up_win     (up_pad[l*lgrs_pkg::LANE_CELLS +: lgrs_pkg::LANE_CELLS+2]),
            .mid_win    (mid_pad[l*lgrs_pkg::LANE_CELLS +: lgrs_pkg::LANE_CELLS+2]),
            .down_win   (down_pad[l*lgrs_pkg::LANE_CELLS +: lgrs_pkg::LANE_CELLS+2]),
            .mask       (job_reg.mask[l*lgrs_pkg::LANE_CELLS +: lgrs_pkg::LANE_CELLS]),
            .next_bits  (lane_res.next_row[l*lgrs_pkg::LANE_CELLS +: lgrs_pkg::LANE_CELLS]),
            .change_cnt (lane_res.counts[l])
        );
    end

    // ------------------------------------------------------------------
    // Merge and output
    // ------------------------------------------------------------------
    lgrs_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (job_valid_reg),
        .res_ready     (res_ready),
        .res           (lane_res),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_row      (next_row),
        .row_changes   (row_changes),
        .frame_changes (frame_changes),
        .frame_last    (frame_last)
    );

endmodule

// ===== rtl/lgrs_checker.sv =====
// ----------------------------------------------------------------------------
// lgrs_checker
// Port-level checks on the result stream of the Life row stencil block.
// ----------------------------------------------------------------------------
module lgrs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [lgrs_pkg::CELLS-1:0]        next_row,
    input  logic [lgrs_pkg::ROW_CNT_W-1:0]    row_changes,
    input  logic [lgrs_pkg::TOTAL_W-1:0]      frame_changes,
    input  logic                              frame_last
);

    logic                           first_reg;
    logic [lgrs_pkg::TOTAL_W-1:0]   total_reg;
    logic [lgrs_pkg::TOTAL_W-1:0]   total_exp;
    logic                           out_xfer;

    assign out_xfer  = out_valid && !out_stall;
    assign total_exp = total_reg + lgrs_pkg::TOTAL_W'(row_changes);

    // Tracks whether the next result opens a frame, and the last total seen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            total_reg <= '0;
        end
        else if (out_xfer)
        begin
            first_reg <= frame_last;
            total_reg <= frame_changes;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_row)
            && $stable(frame_changes) && $stable(frame_last))
        else $error("result changed while stalled");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_changes <= lgrs_pkg::ROW_CNT_W'(lgrs_pkg::CELLS))
        else $error("row change count above row width");

    a_frame_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && first_reg |-> frame_changes == lgrs_pkg::TOTAL_W'(row_changes))
        else $error("frame total did not restart at frame start");

    a_frame_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !first_reg |-> frame_changes == total_exp)
        else $error("frame total is not the running sum of row counts");

endmodule

bind life_generation_row_stencil_top lgrs_checker u_lgrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_row      (next_row),
    .row_changes   (row_changes),
    .frame_changes (frame_changes),
    .frame_last    (frame_last)
);
